// File: hdl/pas_pkg.sv
// shared types and constants of the pointer acceleration scaler
package pas_pkg;

	localparam int DeltaW = 32;
	localparam int ResW   = 16;
	localparam int ProdW  = DeltaW + ResW;
	localparam int NumW   = ProdW + 1;
	localparam int CntW   = 6;
	localparam int IdxW   = 3;

	localparam logic [CntW-1:0] InterpSteps = CntW'(DeltaW);
	localparam logic [CntW-1:0] ScaleSteps  = CntW'(ProdW);

	localparam logic [ResW-1:0] BaseResReset = 16'd1000;
	localparam logic [ResW-1:0] MaxResReset  = 16'd2000;
	localparam logic [ResW-1:0] RampStartReset = 16'd2;
	localparam logic [ResW-1:0] RampFullReset  = 16'd20;

	localparam logic signed [DeltaW-1:0] SatHigh = 32'sd32767;
	localparam logic signed [DeltaW-1:0] SatLow  = -32'sd32768;

	typedef enum logic [IdxW-1:0] {
		REG_BASE_RES  = 3'd0,
		REG_MAX_RES   = 3'd1,
		REG_RAMP_START = 3'd2,
		REG_RAMP_FULL = 3'd3,
		REG_REM_EN    = 3'd4
	} reg_idx_t;

	typedef enum logic [9:0] {
		ST_IDLE  = 10'b00_0000_0001,
		ST_RANGE = 10'b00_0000_0010,
		ST_IMUL  = 10'b00_0000_0100,
		ST_IDIV  = 10'b00_0000_1000,
		ST_IRES  = 10'b00_0001_0000,
		ST_SMUL  = 10'b00_0010_0000,
		ST_SNUM  = 10'b00_0100_0000,
		ST_SLOAD = 10'b00_1000_0000,
		ST_SDIV  = 10'b01_0000_0000,
		ST_FIN   = 10'b10_0000_0000
	} state_t;

endpackage

// File: hdl/pointer_accel_scaler.sv
// pointer acceleration scaler: linear ramp resolution, shared divider, 16-bit saturation
//
// usage
//   s_* channel takes one word: tdata is the event value, tuser flags relative x/y motion.
//   m_* channel returns one word per input: tdata is the scaled (or untouched) value,
//   tuser carries the scaled and clamped flags. cfg_we/cfg_index/cfg_data write the
//   five setup registers; the user must do so only while idle, unchecked by the block.
// timing
//   a pass-through word goes from accept straight to the finish step and the output register.
//   a motion word outside the ramp skips the interpolation, one inside the ramp runs it first;
//   both go through the single restoring divider, one quotient bit per cycle
//   (32 steps for the ramp interpolation, 48 steps for the final scaling).
//   s_tready is high only while the sequencer sits idle; one word is in work at a time.
// reset
//   arst_n clears the sequencer, the output valid and the carried remainder, and
//   loads the register defaults (1000, 2000, 2, 20, remainder on).
// stall
//   the finished word sits in the output register; a new input is taken meanwhile,
//   and the sequencer holds in its last step until the output register frees up.
module pointer_accel_scaler (
	input  logic clk,
	input  logic arst_n,
	// input stream
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [pas_pkg::DeltaW-1:0] s_tdata, // [31:0] in_delta
	input  logic s_tuser,                       // [0] is_rel_xy
	// output stream
	output logic m_tvalid,
	input  logic m_tready,
	output logic [pas_pkg::DeltaW-1:0] m_tdata, // [31:0] out_delta
	output logic [1:0] m_tuser,                 // [0] was_scaled, [1] was_clamped
	// configuration
	input  logic cfg_we,
	input  logic [pas_pkg::IdxW-1:0] cfg_index,
	input  logic [pas_pkg::ResW-1:0] cfg_data
);
	import pas_pkg::*;

	// configuration registers
	logic [ResW-1:0] base_res_q;
	logic [ResW-1:0] max_res_q;
	logic [ResW-1:0] ramp_start_q;
	logic [ResW-1:0] ramp_full_q;
	logic            rem_en_q;

	// state shared by both axes
	logic [ResW-1:0] carry_q;

	// sequencer
	state_t          state_q, state_d;
	logic [CntW-1:0] cnt_q;

	// datapath
	logic [DeltaW-1:0] delta_q;
	logic              motion_q;
	logic              neg_q;
	logic [DeltaW-1:0] mag_q;
	logic              dneg_q;
	logic [ResW-1:0]   res_q;
	logic [ProdW-1:0]  prod_q;
	logic [NumW-1:0]   num_q;
	logic              qneg_q;
	logic [ProdW-1:0]  dq_q;
	logic [ResW-1:0]   rem_q;
	logic [ResW-1:0]   den_q;

	// output register
	logic              m_tvalid_q;
	logic [DeltaW-1:0] m_tdata_q;
	logic [1:0]        m_tuser_q;

	logic s_fire;
	logic out_free;
	logic fin_go;

	// zero base is taken as one everywhere
	logic [ResW-1:0] base_eff;
	// ramp interpolation operands
	logic [ResW:0]   res_diff;
	logic [ResW-1:0] diff_mag;
	logic [ResW-1:0] ramp_offs;
	logic [ResW-1:0] ramp_span;
	logic            at_or_below;
	logic            at_or_above;
	// shared multiplier
	logic [DeltaW-1:0] mul_a;
	logic [ResW-1:0]   mul_b;
	logic [ProdW-1:0]  mul_p;
	// shared divider step
	logic [ResW:0]     trial;
	logic              q_bit;
	logic [ResW-1:0]   rem_next;
	logic              div_last;
	// numerator forming
	logic [NumW-1:0]   prod_ext;
	logic [NumW-1:0]   prod_signed;
	logic [NumW-1:0]   rem_ext;
	logic [NumW-1:0]   num_abs;
	// finish
	logic [ResW-1:0]   quot_lo;
	logic              clamp_pos;
	logic              clamp_neg;
	logic [DeltaW-1:0] scaled_val;
	logic [ResW-1:0]   rem_signed;
	logic [DeltaW-1:0] fin_data;
	logic [1:0]        fin_user;

	assign s_tready = (state_q == ST_IDLE);
	assign s_fire   = s_tvalid & s_tready;
	assign out_free = ~m_tvalid_q | m_tready;
	assign fin_go   = (state_q == ST_FIN) & out_free;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	assign base_eff = (base_res_q == '0) ? ResW'(1) : base_res_q;

	// resolution ramp: signed slope magnitude, offset into the ramp and its length
	assign res_diff    = {1'b0, max_res_q} - {1'b0, base_eff};
	assign diff_mag    = res_diff[ResW] ? ResW'(-res_diff) : res_diff[ResW-1:0];
	assign ramp_offs   = mag_q[ResW-1:0] - ramp_start_q;
	assign ramp_span   = ramp_full_q - ramp_start_q;
	assign at_or_below = mag_q <= {{(DeltaW-ResW){1'b0}}, ramp_start_q};
	assign at_or_above = mag_q >= {{(DeltaW-ResW){1'b0}}, ramp_full_q};

	// one unsigned multiplier serves the ramp slope and the final scaling
	always_comb begin
		if (state_q == ST_IMUL) begin
			mul_a = {{(DeltaW-ResW){1'b0}}, diff_mag};
			mul_b = ramp_offs;
		end else begin
			mul_a = mag_q;
			mul_b = res_q;
		end
	end
	assign mul_p = ProdW'(mul_a) * ProdW'(mul_b);

	// restoring divider, one quotient bit per cycle
	assign trial    = {rem_q, dq_q[ProdW-1]};
	assign q_bit    = trial >= {1'b0, den_q};
	assign rem_next = q_bit ? ResW'(trial - {1'b0, den_q}) : trial[ResW-1:0];
	assign div_last = (cnt_q == CntW'(1));

	// signed numerator: product with the sign of the delta, plus the carried remainder
	assign prod_ext    = {1'b0, prod_q};
	assign prod_signed = neg_q ? (~prod_ext + NumW'(1)) : prod_ext;
	assign rem_ext     = rem_en_q ? {{(NumW-ResW){carry_q[ResW-1]}}, carry_q} : '0;
	assign num_abs     = num_q[NumW-1] ? (~num_q + NumW'(1)) : num_q;

	// saturation and sign restore of quotient and remainder
	assign quot_lo    = dq_q[ResW-1:0];
	assign clamp_pos  = ~qneg_q & (|dq_q[ProdW-1:ResW-1]);
	assign clamp_neg  = qneg_q & ((|dq_q[ProdW-1:ResW]) |
	                    (dq_q[ResW-1] & (|dq_q[ResW-2:0])));
	assign rem_signed = qneg_q ? ResW'(-rem_q) : rem_q;

	always_comb begin
		logic [ResW:0] qs;
		qs = qneg_q ? ((ResW+1)'(0) - {1'b0, quot_lo}) : {1'b0, quot_lo};
		scaled_val = {{(DeltaW-ResW-1){qs[ResW]}}, qs};
		if (!motion_q) begin
			fin_data = delta_q;
			fin_user = 2'b00;
		end else if (clamp_pos) begin
			fin_data = SatHigh;
			fin_user = 2'b11;
		end else if (clamp_neg) begin
			fin_data = SatLow;
			fin_user = 2'b11;
		end else begin
			fin_data = scaled_val;
			fin_user = 2'b01;
		end
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (s_fire) begin
				state_d = s_tuser ? ST_RANGE : ST_FIN;
			end
			ST_RANGE: begin
				if (at_or_below || at_or_above) begin
					state_d = ST_SMUL;
				end else begin
					state_d = ST_IMUL;
				end
			end
			ST_IMUL:  state_d = ST_IDIV;
			ST_IDIV:  if (div_last) begin
				state_d = ST_IRES;
			end
			ST_IRES:  state_d = ST_SMUL;
			ST_SMUL:  state_d = ST_SNUM;
			ST_SNUM:  state_d = ST_SLOAD;
			ST_SLOAD: state_d = ST_SDIV;
			ST_SDIV:  if (div_last) begin
				state_d = ST_FIN;
			end
			ST_FIN:   if (out_free) begin
				state_d = ST_IDLE;
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IMUL) begin
				cnt_q <= InterpSteps;
			end else if (state_q == ST_SLOAD) begin
				cnt_q <= ScaleSteps;
			end else if (state_q == ST_IDIV || state_q == ST_SDIV) begin
				cnt_q <= cnt_q - CntW'(1);
			end
		end
	end

	// configuration writes, indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_res_q   <= BaseResReset;
			max_res_q    <= MaxResReset;
			ramp_start_q <= RampStartReset;
			ramp_full_q  <= RampFullReset;
			rem_en_q     <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BASE_RES:   base_res_q   <= cfg_data;
				REG_MAX_RES:    max_res_q    <= cfg_data;
				REG_RAMP_START: ramp_start_q <= cfg_data;
				REG_RAMP_FULL:  ramp_full_q  <= cfg_data;
				REG_REM_EN:     rem_en_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// carried remainder: untouched on pass-through or with the carry off, zero on clamp
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carry_q <= '0;
		end else if (fin_go && motion_q && rem_en_q) begin
			carry_q <= fin_user[1] ? '0 : rem_signed;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (fin_go) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			m_tdata_q <= fin_data;
			m_tuser_q <= fin_user;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: if (s_fire) begin
				delta_q  <= s_tdata;
				motion_q <= s_tuser;
				neg_q    <= s_tdata[DeltaW-1];
				mag_q    <= s_tdata[DeltaW-1] ? (~s_tdata + DeltaW'(1)) : s_tdata;
			end
			ST_RANGE: begin
				dneg_q <= res_diff[ResW];
				if (at_or_below) begin
					res_q <= base_eff;
				end else if (at_or_above) begin
					res_q <= max_res_q;
				end
			end
			ST_IMUL: begin
				dq_q  <= {mul_p[DeltaW-1:0], {(ProdW-DeltaW){1'b0}}};
				rem_q <= '0;
				den_q <= ramp_span;
			end
			ST_IDIV, ST_SDIV: begin
				dq_q  <= {dq_q[ProdW-2:0], q_bit};
				rem_q <= rem_next;
			end
			ST_IRES: begin
				res_q <= dneg_q ? (base_eff - quot_lo) : (base_eff + quot_lo);
			end
			ST_SMUL: begin
				prod_q <= mul_p;
			end
			ST_SNUM: begin
				num_q <= prod_signed + rem_ext;
			end
			ST_SLOAD: begin
				qneg_q <= num_q[NumW-1];
				dq_q   <= num_abs[ProdW-1:0];
				rem_q  <= '0;
				den_q  <= base_eff;
			end
			ST_FIN: ;
			default: ;
		endcase
	end

	// checks
	a_clamp_implies_scaled: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[1] && !m_tuser[0]))
		else $error("clamped flag without scaled flag");

	a_scaled_fits_int16: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |->
		(m_tdata[DeltaW-1:ResW-1] == '0) || (m_tdata[DeltaW-1:ResW-1] == '1))
		else $error("scaled output outside 16-bit range");

	a_div_count_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDIV || state_q == ST_SDIV) |-> cnt_q != '0)
		else $error("divider running with zero step count");

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && motion_q) |-> rem_q < den_q)
		else $error("divider remainder not below divisor");

	a_carry_only_at_finish: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(carry_q) |-> $past(state_q == ST_FIN))
		else $error("carried remainder changed outside the finish step");

	a_ready_only_idle_seq: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !s_tuser |=> state_q == ST_FIN)
		else $error("pass-through word did not go straight to finish");

endmodule
